>>> sv/lap_pkg.sv
// ----------------------------------------------------------------------------
// lap_pkg
// Shared types and constants of the 3x3 Laplacian edge filter.
// ----------------------------------------------------------------------------
package lap_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int DIM_W       = 12;
	localparam int PIX_W       = 32;
	localparam int CH_W        = 8;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [DIM_W-1:0] ROW_MAX      = '1;

	// register index, taken from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pixel_t;

	// line store entry: pixel two rows back and one row back
	typedef struct packed {
		pixel_t upper;
		pixel_t middle;
	} line_pair_t;

	// 3x3 window, index column*3 + row, column 0 = left, row 0 = top
	typedef pixel_t [8:0] window_t;

	typedef struct packed {
		logic left;
		logic right;
		logic top;
		logic bottom;
		logic last;
	} tap_ctl_t;

	typedef struct packed {
		logic            last;
		logic [CH_W-1:0] alpha;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} result_t;

endpackage

>>> sv/lap_kernel.sv
// ----------------------------------------------------------------------------
// lap_kernel
// Laplacian sum over one 3x3 window for red, green and blue, with edge
// masking and clamping to 0..255; alpha of the center pixel passes through.
// ----------------------------------------------------------------------------
module lap_kernel (
	input  lap_pkg::window_t  taps,
	input  lap_pkg::tap_ctl_t ctl,
	output lap_pkg::result_t  result
);
	import lap_pkg::*;

	logic              use_tap [9];
	logic signed [12:0] acc    [3];
	logic [CH_W-1:0]   chan   [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			use_tap[c*3 + 0] = ((c == 0) ? ctl.left : (c == 2) ? ctl.right : 1'b1) & ctl.top;
			use_tap[c*3 + 1] = (c == 0) ? ctl.left : (c == 2) ? ctl.right : 1'b1;
			use_tap[c*3 + 2] = ((c == 0) ? ctl.left : (c == 2) ? ctl.right : 1'b1) & ctl.bottom;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			acc[ch] = $signed({2'b00, taps[4][ch*CH_W +: CH_W], 3'b000});
			for (int k = 0; k < 9; k++) begin
				if (k != 4 && use_tap[k])
					acc[ch] = acc[ch] - $signed({5'b00000, taps[k][ch*CH_W +: CH_W]});
			end
			if (acc[ch] < 13'sd0)
				chan[ch] = '0;
			else if (acc[ch] > 13'sd255)
				chan[ch] = '1;
			else
				chan[ch] = acc[ch][CH_W-1:0];
		end
	end

	assign result.red   = chan[0];
	assign result.green = chan[1];
	assign result.blue  = chan[2];
	assign result.alpha = taps[4][PIX_W-1 -: CH_W];
	assign result.last  = ctl.last;

endmodule

>>> sv/lap_out_fifo.sv
// ----------------------------------------------------------------------------
// lap_out_fifo
// Small result queue in front of the master stream port; its fill count
// lets the input side reserve room for every item still in the pipeline.
// ----------------------------------------------------------------------------
module lap_out_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  lap_pkg::result_t           push_data,
	output logic                       pop_valid,
	input  logic                       pop_ready,
	output lap_pkg::result_t           pop_data,
	output logic [lap_pkg::FIFO_CNT_W-1:0] count
);
	import lap_pkg::*;

	result_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = fifo_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/laplacian_3x3_edge_filter.sv
// ----------------------------------------------------------------------------
// laplacian_3x3_edge_filter
// 3x3 Laplacian edge filter over a raster stream of RGBA pixels.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock and delivers one result per clock in steady
// state while m_tready is high; the first result of a frame appears one row
// plus one pixel after its input, and after the last pixel of a frame the
// source sends frame_width+1 drain transfers (tuser high) to flush it out; the
// final output of the frame carries tlast. Both line stores share one 2048x64
// RAM with one read and one write port: each pixel reads its column entry
// on the transfer cycle and writes it back the next cycle, with a bypass
// when back-to-back pixels hit the same column (frame width 1). A transfer
// is registered in stages s1 and s2, then queued. Taps outside the frame count
// as zero; alpha is the center pixel's own. Width is clipped to 1..2048
// and height 0 acts as 1; program the registers only while the block is idle.
// ----------------------------------------------------------------------------
module laplacian_3x3_edge_filter (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // in_red, in_green, in_blue, in_alpha
	input  logic        s_tuser,   // drain
	// filtered output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
	output logic        m_tlast    // frame_last
);
	import lap_pkg::*;

	// configuration
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic             cfg_wr;

	// raster counters
	logic [COL_W-1:0] in_col_q;
	logic [DIM_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [DIM_W-1:0] out_row_q;

	// input stage
	logic             accept;
	logic [DIM_W-1:0] col0;
	logic [DIM_W-1:0] row0;
	logic [DIM_W-1:0] row_inc;
	logic [DIM_W-1:0] col1;
	logic [DIM_W-1:0] col_nx;
	logic [DIM_W-1:0] row_nx;
	logic             emit;
	logic [DIM_W-1:0] oc_p1;
	logic [DIM_W:0]   or_p1;
	logic [DIM_W-1:0] oc_nx;
	logic [DIM_W-1:0] or_nx;
	logic [COL_W-1:0] idx_s0;
	pixel_t           px_s0;
	tap_ctl_t         ctl_s0;

	// memory stage
	line_pair_t       mem_q [MAX_WIDTH];
	line_pair_t       rd_s1;
	line_pair_t       fwd_data_s1;
	line_pair_t       pair_s1;
	line_pair_t       wr_data_s1;
	logic             valid_s1;
	logic             fwd_s1;
	logic [COL_W-1:0] idx_s1;
	pixel_t           px_s1;
	logic             emit_s1;
	tap_ctl_t         ctl_s1;
	window_t          win_q;

	// filter stage
	logic             valid_s2;
	tap_ctl_t         ctl_s2;
	result_t          res_s2;
	result_t          out_res;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic [FIFO_CNT_W-1:0] in_flight;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {20'd0, height_q} : {20'd0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_WIDTH)
				width_q <= pwdata[DIM_W-1:0];
			else
				height_q <= pwdata[DIM_W-1:0];
		end
	end

	always_comb begin
		if (width_q == '0)
			w_eff = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_WIDTH))
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = width_q;
		h_eff = (height_q == '0) ? DIM_W'(1) : height_q;
	end

	// ---------------- input stage: counters and read ----------------
	assign in_flight = fifo_count + FIFO_CNT_W'(valid_s1) + FIFO_CNT_W'(valid_s2);
	assign s_tready  = in_flight < FIFO_CNT_W'(FIFO_DEPTH);
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		// column left over from a wider geometry wraps first
		if ({1'b0, in_col_q} >= w_eff) begin
			col0 = '0;
			row0 = (in_row_q != ROW_MAX) ? in_row_q + 1'b1 : in_row_q;
		end else begin
			col0 = {1'b0, in_col_q};
			row0 = in_row_q;
		end
		emit    = (row0 >= DIM_W'(2)) || (row0 == DIM_W'(1) && col0 != '0);
		row_inc = (row0 != ROW_MAX) ? row0 + 1'b1 : row0;
		col1    = col0 + 1'b1;
		if (col1 >= w_eff) begin
			col_nx = '0;
			row_nx = row_inc;
		end else begin
			col_nx = col1;
			row_nx = row0;
		end

		oc_p1 = {1'b0, out_col_q} + 1'b1;
		or_p1 = {1'b0, out_row_q} + 1'b1;
		ctl_s0.left   = (out_col_q != '0);
		ctl_s0.right  = oc_p1 < w_eff;
		ctl_s0.top    = (out_row_q != '0);
		ctl_s0.bottom = or_p1 < {1'b0, h_eff};
		ctl_s0.last   = (oc_p1 >= w_eff) && (or_p1 >= {1'b0, h_eff});
		if (oc_p1 >= w_eff) begin
			oc_nx = '0;
			or_nx = or_p1[DIM_W-1:0];
		end else begin
			oc_nx = oc_p1;
			or_nx = out_row_q;
		end

		idx_s0 = col0[COL_W-1:0];
		px_s0  = s_tuser ? '0 : s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (emit && ctl_s0.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= col_nx[COL_W-1:0];
				in_row_q <= row_nx;
				if (emit) begin
					out_col_q <= oc_nx[COL_W-1:0];
					out_row_q <= or_nx;
				end
			end
		end
	end

	// ---------------- memory stage: read-modify-write of line stores ----------------
	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= mem_q[idx_s0];
		if (valid_s1)
			mem_q[idx_s1] <= wr_data_s1;
	end

	// same-column read in the cycle of the write sees old data: bypass it
	assign pair_s1           = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign wr_data_s1.upper  = pair_s1.middle;
	assign wr_data_s1.middle = px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept)
				fwd_s1 <= valid_s1 && (idx_s1 == idx_s0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1      <= idx_s0;
			px_s1       <= px_s0;
			emit_s1     <= emit;
			ctl_s1      <= ctl_s0;
			fwd_data_s1 <= wr_data_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r]     <= win_q[3 + r];
				win_q[3 + r] <= win_q[6 + r];
			end
			win_q[6] <= pair_s1.upper;
			win_q[7] <= pair_s1.middle;
			win_q[8] <= px_s1;
		end
	end

	// ---------------- filter stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1 && emit_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			ctl_s2 <= ctl_s1;
	end

	lap_kernel u_kernel (
		.taps   (win_q),
		.ctl    (ctl_s2),
		.result (res_s2)
	);

	lap_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2),
		.push_data (res_s2),
		.pop_valid (m_tvalid),
		.pop_ready (m_tready),
		.pop_data  (out_res),
		.count     (fifo_count)
	);

	assign m_tdata = {out_res.alpha, out_res.blue, out_res.green, out_res.red};
	assign m_tlast = out_res.last;

	// ---------------- assertions ----------------
	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)))
		else $error("result queue overflow");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit && ctl_s0.last) |=>
			(in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0))
		else $error("counters not cleared after last pixel of frame");

	a_bypass_col: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fwd_s1 && $past(valid_s1)) |-> (idx_s1 == $past(idx_s1)))
		else $error("bypass taken for a different column");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 Laplacian edge filter.
// ----------------------------------------------------------------------------
// Streams RGBA frames of many geometries through the filter. Both stream
// sides idle at random. Each pixel transfer feeds a cycle-free model of the
// line stores, the 3x3 window and the border masks. Every output transfer is
// checked field by field against the oldest predicted pixel. Geometry
// registers are written over APB between frames, once the filter has gone
// quiet, and are read back.
// ----------------------------------------------------------------------------
module tb;
	import lap_pkg::*;

	localparam int STALL_MAX        = 16;
	localparam int SETTLE_CYCLES    = 8;
	localparam int TAIL_CYCLES      = 20;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int RANDOM_ITEMS     = 600;
	localparam int MISMATCH_REPORTS = 10;
	localparam int TALL_ROWS        = 200;
	localparam logic [31:0] WIDE_WORD = 32'hFFFF_F060;

	typedef enum int {FILL_NOISE, FILL_SMOOTH, FILL_BINARY} fill_e;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // in_red, in_green, in_blue, in_alpha
	logic        s_tuser;   // drain
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // out_red, out_green, out_blue, out_alpha
	logic        m_tlast;   // frame_last

	laplacian_3x3_edge_filter DUT (.*);

	// filter model state
	logic [DIM_W-1:0] cfg_width;
	logic [DIM_W-1:0] cfg_height;
	pixel_t           upper_hist [MAX_WIDTH];
	pixel_t           middle_hist [MAX_WIDTH];
	pixel_t           taps [9];   // column*3 + row
	int unsigned      col_in, row_in, col_out, row_out;
	result_t          pending_pixels [$];

	int mismatches, results_checked, items_sent, frames_sent, idle_cycles;
	bit tx_burst, rx_burst;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned active_width();
		if (cfg_width == 0)
			return 1;
		if (cfg_width > MAX_WIDTH)
			return MAX_WIDTH;
		return 32'(cfg_width);
	endfunction

	function automatic int unsigned active_height();
		return (cfg_height == 0) ? 1 : 32'(cfg_height);
	endfunction

	function automatic void check_value(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MISMATCH_REPORTS)
				$display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
		end
	endfunction

	function automatic logic [CH_W-1:0] laplacian_channel(int sh, logic [8:0] taps_on);
		int acc;
		int k;
		acc = 0;
		for (k = 0; k < 9; k++) begin
			if (taps_on[k]) begin
				if (k == 4)
					acc += 8 * int'(taps[k][sh +: CH_W]);
				else
					acc -= int'(taps[k][sh +: CH_W]);
			end
		end
		if (acc < 0)
			acc = 0;
		if (acc > 255)
			acc = 255;
		return acc[CH_W-1:0];
	endfunction

	function automatic void reset_model();
		int i;
		cfg_width = WIDTH_RESET;
		cfg_height = HEIGHT_RESET;
		for (i = 0; i < MAX_WIDTH; i++) begin
			upper_hist[i] = '0;
			middle_hist[i] = '0;
		end
		for (i = 0; i < 9; i++)
			taps[i] = '0;
		col_in = 0;
		row_in = 0;
		col_out = 0;
		row_out = 0;
	endfunction

	// one accepted transfer: shift the line stores and window, queue the
	// output pixel if the window center is inside the frame yet
	function automatic void predict_filtered_pixel(logic drain, pixel_t data);
		int unsigned w, h, idx, c;
		pixel_t px, up, mid;
		logic emit, at_end, cu;
		logic [8:0] taps_on;
		result_t r;
		w = active_width();
		h = active_height();
		if (col_in >= w) begin
			col_in = 0;
			if (row_in < ROW_MAX)
				row_in++;
		end
		px = drain ? '0 : data;
		idx = col_in % MAX_WIDTH;
		up = upper_hist[idx];
		mid = middle_hist[idx];
		upper_hist[idx] = mid;
		middle_hist[idx] = px;
		for (c = 0; c < 3; c++) begin
			taps[c] = taps[3 + c];
			taps[3 + c] = taps[6 + c];
		end
		taps[6] = up;
		taps[7] = mid;
		taps[8] = px;
		emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
		col_in++;
		if (col_in >= w) begin
			col_in = 0;
			if (row_in < ROW_MAX)
				row_in++;
		end
		if (!emit)
			return;
		for (c = 0; c < 3; c++) begin
			cu = (c == 0) ? (col_out > 0) : (c == 2) ? (col_out + 1 < w) : 1'b1;
			taps_on[c*3]     = cu && (row_out > 0);
			taps_on[c*3 + 1] = cu;
			taps_on[c*3 + 2] = cu && (row_out + 1 < h);
		end
		r.red   = laplacian_channel(0, taps_on);
		r.green = laplacian_channel(8, taps_on);
		r.blue  = laplacian_channel(16, taps_on);
		r.alpha = taps[4][24 +: CH_W];
		at_end = (col_out + 1 >= w) && (row_out + 1 >= h);
		r.last = at_end;
		pending_pixels.push_back(r);
		if (at_end) begin
			col_out = 0;
			row_out = 0;
			col_in = 0;
			row_in = 0;
		end else begin
			col_out++;
			if (col_out >= w) begin
				col_out = 0;
				row_out++;
			end
		end
	endfunction

	function automatic pixel_t frame_pixel(fill_e fill, pixel_t base);
		pixel_t p;
		int b;
		p = $urandom;
		for (b = 0; b < 3; b++) begin
			if (fill == FILL_SMOOTH)
				p[8*b +: CH_W] = base[8*b +: CH_W] ^ CH_W'($urandom_range(0, 7));
			else if (fill == FILL_BINARY)
				p[8*b +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return p;
	endfunction

	// APB tasks start and end on a rising edge with the bus idle
	task automatic reg_write(logic idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_WIDTH)
			cfg_width = value[DIM_W-1:0];
		else
			cfg_height = value[DIM_W-1:0];
		@(posedge clk);
	endtask

	task automatic reg_read(logic idx);
		logic [31:0] want;
		want = (idx == REG_WIDTH) ? 32'(cfg_width) : 32'(cfg_height);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		check_value(idx == REG_WIDTH ? "frame_width readback" : "frame_height readback",
			want, prdata);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(logic [31:0] width_word, logic [31:0] height_word);
		reg_write(REG_WIDTH, width_word);
		reg_write(REG_HEIGHT, height_word);
		reg_read(REG_WIDTH);
		reg_read(REG_HEIGHT);
	endtask

	task automatic send_pixel(logic drain, pixel_t data);
		int gap;
		if ($urandom_range(0, 63) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, STALL_MAX);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= drain;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		predict_filtered_pixel(drain, data);
		items_sent++;
	endtask

	// width*height pixels then width+1 drain transfers; a noisy frame swaps
	// the kind of an occasional transfer
	task automatic send_frame(fill_e fill, bit noisy);
		int unsigned n_pix, total, i;
		pixel_t base;
		logic drain;
		n_pix = active_width() * active_height();
		total = n_pix + active_width() + 1;
		base = $urandom;
		for (i = 0; i < total; i++) begin
			drain = (i >= n_pix);
			if (noisy && $urandom_range(0, 15) == 0)
				drain = !drain;
			send_pixel(drain, frame_pixel(fill, base));
		end
		frames_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_register_reset();
		reg_read(REG_WIDTH);
		reg_read(REG_HEIGHT);
	endtask

	// clamping both ways, a drain tick inside the frame and a pixel in the flush
	task automatic test_directed_frame();
		pixel_t pix [13] = '{
			32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hA5FF_FFFF, 32'h0110_2030,
			32'h5AFF_FFFF, 32'hFF00_0000, 32'h3CC3_8118,
			32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000};
		logic drains [13] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
			1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		int i;
		set_geometry(32'd3, 32'd3);
		for (i = 0; i < 13; i++)
			send_pixel(drains[i], pix[i]);
		frames_sent++;
		wait_idle();
	endtask

	// zero width and height act as one; a second frame follows the first directly
	task automatic test_degenerate_geometry();
		set_geometry(32'd0, 32'd0);
		send_frame(FILL_BINARY, 1'b0);
		send_frame(FILL_NOISE, 1'b0);
		wait_idle();
	endtask

	// a width word with high bits set keeps only its low 12 bits
	task automatic test_widest_row();
		set_geometry(WIDE_WORD, 32'd1);
		send_frame(FILL_SMOOTH, 1'b0);
		wait_idle();
	endtask

	task automatic test_tallest_column();
		set_geometry(32'd1, 32'(TALL_ROWS));
		send_frame(FILL_SMOOTH, 1'b0);
		wait_idle();
	endtask

	task automatic test_random_frames();
		int start, frames;
		logic [DIM_W-1:0] w, h;
		start = items_sent;
		while (items_sent < start + RANDOM_ITEMS) begin
			w = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 40))
				: DIM_W'($urandom_range(1, 8));
			h = DIM_W'($urandom_range(0, 6));
			set_geometry({$urandom_range(0, 1) ? 20'($urandom) : 20'd0, w},
				{$urandom_range(0, 1) ? 20'($urandom) : 20'd0, h});
			frames = $urandom_range(1, 3);
			repeat (frames)
				send_frame(fill_e'($urandom_range(0, 2)), $urandom_range(0, 3) == 0);
			wait_idle();
		end
	endtask

	// output side: random stall before each transfer, then check it
	initial begin : result_monitor
		int stall;
		result_t got, want;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, STALL_MAX);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			got = {m_tlast, m_tdata};
			@(posedge clk);
			results_checked++;
			if (pending_pixels.size() == 0) begin
				check_value("unexpected output pixel", 'x, 32'(got));
			end else begin
				want = pending_pixels.pop_front();
				check_value("out_red", 32'(want.red), 32'(got.red));
				check_value("out_green", 32'(want.green), 32'(got.green));
				check_value("out_blue", 32'(want.blue), 32'(got.blue));
				check_value("out_alpha", 32'(want.alpha), 32'(got.alpha));
				check_value("frame_last", 32'(want.last), 32'(got.last));
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d pixels outstanding",
					idle_cycles, pending_pixels.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		mismatches = 0;
		results_checked = 0;
		items_sent = 0;
		frames_sent = 0;
		idle_cycles = 0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed_frame();
		test_degenerate_geometry();
		test_widest_row();
		test_tallest_column();
		test_random_frames();
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_pixels.size() != 0)
			check_value("output pixels never delivered", 0, pending_pixels.size());
		$display("%0d frames, %0d input transfers, %0d output pixels checked",
			frames_sent, items_sent, results_checked);
		$display("widths 0..40 and 96 from a padded word, heights 0..6 and %0d, %0d mismatches",
			TALL_ROWS, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> laplacian_3x3_edge_filter.f
sv/lap_pkg.sv
sv/lap_kernel.sv
sv/lap_out_fifo.sv
sv/laplacian_3x3_edge_filter.sv
bench/tb.sv
